### sv/mfu_pkg.sv
// Shared types and constants for the most-frequently-used page replacement block.
package mfu_pkg;

  // Field widths fixed by the beat formats.
  localparam int IN_PAGE_W   = 16;
  localparam int SLOT_OUT_W  = 4;
  localparam int FAULT_W     = 32;
  localparam int CNT_W       = 16;
  localparam int STAMP_W     = 32;
  localparam int FIU_W       = 5;

  // Widest values that the parameters can call for, used by the scan result.
  localparam int SLOT_MAX_W  = 8;
  localparam int PAGE_MAX_W  = 32;

  // Saturation limits.
  localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};
  localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

  // Configuration register addresses.
  localparam logic [1:0] CFG_ADDR_FRAMES_IN_USE = 2'd0;
  localparam logic [FIU_W-1:0] FIU_RESET = 5'd16;

  // One input beat.
  typedef struct packed {
    logic [IN_PAGE_W-1:0] page;
    logic                 last_of_string;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    logic                  hit;
    logic [SLOT_OUT_W-1:0] frame_slot;
    logic                  evicted_valid;
    logic [IN_PAGE_W-1:0]  evicted_page;
    logic [FAULT_W-1:0]    fault_total;
    logic                  string_done;
  } out_beat_t;

  // Control from the sequencer to the scan unit.
  typedef struct packed {
    logic start;
    logic step;
  } scan_ctl_t;

  // Findings of the scan unit after a full pass.
  typedef struct packed {
    logic                  hit;
    logic [SLOT_MAX_W-1:0] hit_slot;
    logic [CNT_W-1:0]      hit_cnt;
    logic                  empty;
    logic [SLOT_MAX_W-1:0] empty_slot;
    logic [SLOT_MAX_W-1:0] vict_slot;
    logic [PAGE_MAX_W-1:0] vict_page;
  } scan_res_t;

endpackage

### sv/mfu_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module mfu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/mfu_scan.sv
// Shared compare unit that scans one frame per cycle, while step is set, for hit, empty frame and victim.
module mfu_scan #(
  parameter int IDX_W     = 4,
  parameter int PAGE_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mfu_pkg::scan_ctl_t        ctl,
  input  logic [IDX_W-1:0]          idx,
  input  logic                      frame_vld,
  input  logic [PAGE_BITS-1:0]      frame_page,
  input  logic [mfu_pkg::CNT_W-1:0] frame_cnt,
  input  logic [mfu_pkg::STAMP_W-1:0] frame_stamp,
  input  logic [PAGE_BITS-1:0]      ref_page,
  output mfu_pkg::scan_res_t        res
);

  logic                        hit_r, hit_nxt;
  logic [IDX_W-1:0]            hit_idx_r, hit_idx_nxt;
  logic [mfu_pkg::CNT_W-1:0]   hit_cnt_r, hit_cnt_nxt;
  logic                        emp_r, emp_nxt;
  logic [IDX_W-1:0]            emp_idx_r, emp_idx_nxt;
  logic [IDX_W-1:0]            best_idx_r, best_idx_nxt;
  logic [mfu_pkg::CNT_W-1:0]   best_cnt_r, best_cnt_nxt;
  logic [mfu_pkg::STAMP_W-1:0] best_stamp_r, best_stamp_nxt;
  logic [PAGE_BITS-1:0]        best_page_r, best_page_nxt;
  logic                        match;
  logic                        better;

  // The compare unit: page match and victim ordering for the frame now read.
  assign match  = frame_vld && (frame_page == ref_page);
  assign better = (frame_cnt > best_cnt_r) ||
                  ((frame_cnt == best_cnt_r) && (frame_stamp < best_stamp_r));

  // Fold the current frame into the running findings.
  always_comb begin
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_cnt_nxt    = hit_cnt_r;
    emp_nxt        = emp_r;
    emp_idx_nxt    = emp_idx_r;
    best_idx_nxt   = best_idx_r;
    best_cnt_nxt   = best_cnt_r;
    best_stamp_nxt = best_stamp_r;
    best_page_nxt  = best_page_r;
    if (ctl.start) begin
      hit_nxt = 1'b0;
      emp_nxt = 1'b0;
    end else if (ctl.step) begin
      if (!hit_r && match) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = idx;
        hit_cnt_nxt = frame_cnt;
      end
      if (!emp_r && !frame_vld) begin
        emp_nxt     = 1'b1;
        emp_idx_nxt = idx;
      end
      // The first frame seeds the victim; later ones replace it only when better.
      if ((idx == '0) || better) begin
        best_idx_nxt   = idx;
        best_cnt_nxt   = frame_cnt;
        best_stamp_nxt = frame_stamp;
        best_page_nxt  = frame_page;
      end
    end
  end

  // Found flags are control state; the captured values are payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
      emp_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
      emp_r <= emp_nxt;
    end
    hit_idx_r    <= hit_idx_nxt;
    hit_cnt_r    <= hit_cnt_nxt;
    emp_idx_r    <= emp_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_cnt_r   <= best_cnt_nxt;
    best_stamp_r <= best_stamp_nxt;
    best_page_r  <= best_page_nxt;
  end

  // Present the findings at the widest widths.
  assign res.hit        = hit_r;
  assign res.hit_slot   = mfu_pkg::SLOT_MAX_W'(hit_idx_r);
  assign res.hit_cnt    = hit_cnt_r;
  assign res.empty      = emp_r;
  assign res.empty_slot = mfu_pkg::SLOT_MAX_W'(emp_idx_r);
  assign res.vict_slot  = mfu_pkg::SLOT_MAX_W'(best_idx_r);
  assign res.vict_page  = mfu_pkg::PAGE_MAX_W'(best_page_r);

endmodule

### sv/mfu_page_replacement_top.sv
// Top level of the most-frequently-used page replacement block: sequencer, table and ports.
//
//  Channel   Direction  Handshake                   Beat
//  in_       input      in_valid / in_stall          page, last_of_string
//  out_      output     out_valid / out_stall        hit, slot, eviction, fault total, done
//  cfg_      input      APB psel/penable/pwrite      frames_in_use at address 0
//
// Each reference is accepted, then the table is read once per frame in use through its
// registered read port, each frame is compared, and the chosen frame is written back.
// The single table read port and the one shared compare unit take the frames one at a time.
// Reset clears the valid marks and counters and sets the configuration to its reset value at once; no clearing pass.
// A waiting result holds the write-back until out_stall falls; in_stall is low only when idle.
module mfu_page_replacement_top #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mfu_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mfu_pkg::out_beat_t  out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [1:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int WORD_W = PAGE_BITS + mfu_pkg::CNT_W + mfu_pkg::STAMP_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  state_t                       state_r, state_nxt;
  logic [mfu_pkg::FIU_W-1:0]    fiu_r, fiu_nxt;
  logic [FRAMES-1:0]            valid_r, valid_nxt;
  logic [mfu_pkg::STAMP_W-1:0]  stamp_r, stamp_nxt;
  logic [mfu_pkg::FAULT_W-1:0]  fault_r, fault_nxt;
  logic [PAGE_BITS-1:0]         page_r, page_nxt;
  logic                         last_r, last_nxt;
  logic [IDX_W-1:0]             rd_idx_r, rd_idx_nxt;
  logic                         rd_done_r, rd_done_nxt;
  logic [IDX_W-1:0]             cmp_idx_r, cmp_idx_nxt;
  logic                         cmp_vld_r, cmp_vld_nxt;
  logic                         out_valid_r, out_valid_nxt;
  mfu_pkg::out_beat_t           out_data_r, out_data_nxt;

  logic                         in_acc;
  logic                         cfg_wr;
  logic                         out_free;
  logic [8:0]                   lim;
  logic [IDX_W-1:0]             last_idx;
  logic                         issue;
  logic                         scan_end;
  logic                         commit;
  mfu_pkg::scan_ctl_t           scan_ctl;
  mfu_pkg::scan_res_t           scan_res;
  logic [WORD_W-1:0]            ram_wdata;
  logic [WORD_W-1:0]            ram_rdata;
  logic [IDX_W-1:0]             slot;
  logic                         ev_valid;
  logic [PAGE_BITS-1:0]         ev_page;
  logic [mfu_pkg::CNT_W-1:0]    cnt_new;
  logic [mfu_pkg::STAMP_W-1:0]  stamp_new;
  logic [mfu_pkg::FAULT_W-1:0]  fault_new;

  // Handshakes.
  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == mfu_pkg::CFG_ADDR_FRAMES_IN_USE);
  assign cfg_prdata = (cfg_paddr == mfu_pkg::CFG_ADDR_FRAMES_IN_USE) ?
                      32'(fiu_r) : 32'd0;

  // Frames in use, with zero taken as one and anything above the table taken as the table.
  always_comb begin
    lim = 9'(fiu_r);
    if (lim == 9'd0) begin
      lim = 9'd1;
    end
    if (lim > 9'(FRAMES)) begin
      lim = 9'(FRAMES);
    end
  end
  assign last_idx = IDX_W'(lim - 9'd1);

  // Scan pacing: one read issued per cycle, compared in the next cycle.
  assign issue    = (state_r == ST_SCAN) && !rd_done_r;
  assign scan_end = (state_r == ST_SCAN) && cmp_vld_r && (cmp_idx_r == last_idx);
  assign commit   = (state_r == ST_UPD) && out_free;

  assign scan_ctl.start = in_acc;
  assign scan_ctl.step  = cmp_vld_r;

  // Table of pages, use counts and stamps.
  mfu_ram #(
    .WIDTH (WORD_W),
    .DEPTH (FRAMES)
  ) u_table (
    .clk   (clk),
    .we    (commit),
    .waddr (slot),
    .wdata (ram_wdata),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  mfu_scan #(
    .IDX_W     (IDX_W),
    .PAGE_BITS (PAGE_BITS)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (scan_ctl),
    .idx         (cmp_idx_r),
    .frame_vld   (valid_r[cmp_idx_r]),
    .frame_page  (ram_rdata[WORD_W-1 -: PAGE_BITS]),
    .frame_cnt   (ram_rdata[mfu_pkg::STAMP_W +: mfu_pkg::CNT_W]),
    .frame_stamp (ram_rdata[mfu_pkg::STAMP_W-1:0]),
    .ref_page    (page_r),
    .res         (scan_res)
  );

  // Decision after the scan: hit frame, else lowest empty frame, else the victim.
  always_comb begin
    ev_valid = 1'b0;
    ev_page  = '0;
    cnt_new  = 16'd1;
    if (scan_res.hit) begin
      slot    = IDX_W'(scan_res.hit_slot);
      cnt_new = (scan_res.hit_cnt == mfu_pkg::CNT_MAX) ? scan_res.hit_cnt :
                scan_res.hit_cnt + 16'd1;
    end else if (scan_res.empty) begin
      slot = IDX_W'(scan_res.empty_slot);
    end else begin
      slot     = IDX_W'(scan_res.vict_slot);
      ev_valid = 1'b1;
      ev_page  = PAGE_BITS'(scan_res.vict_page);
    end
  end

  assign stamp_new = (stamp_r == mfu_pkg::STAMP_MAX) ? stamp_r : stamp_r + 32'd1;
  assign fault_new = (scan_res.hit || (fault_r == mfu_pkg::FAULT_MAX)) ? fault_r :
                     fault_r + 32'd1;
  assign ram_wdata = {page_r, cnt_new, stamp_new};

  // Sequencer and state updates.
  always_comb begin
    state_nxt     = state_r;
    fiu_nxt       = fiu_r;
    valid_nxt     = valid_r;
    stamp_nxt     = stamp_r;
    fault_nxt     = fault_r;
    page_nxt      = page_r;
    last_nxt      = last_r;
    rd_idx_nxt    = rd_idx_r;
    rd_done_nxt   = rd_done_r;
    cmp_idx_nxt   = rd_idx_r;
    cmp_vld_nxt   = issue;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (cfg_wr) begin
      fiu_nxt = cfg_pwdata[mfu_pkg::FIU_W-1:0];
    end
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          page_nxt    = PAGE_BITS'(in_data.page);
          last_nxt    = in_data.last_of_string;
          rd_idx_nxt  = '0;
          rd_done_nxt = 1'b0;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          if (rd_idx_r == last_idx) begin
            rd_done_nxt = 1'b1;
          end else begin
            rd_idx_nxt = rd_idx_r + IDX_W'(1);
          end
        end
        if (scan_end) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (commit) begin
          valid_nxt[slot]            = 1'b1;
          stamp_nxt                  = stamp_new;
          fault_nxt                  = fault_new;
          out_valid_nxt              = 1'b1;
          out_data_nxt.hit           = scan_res.hit;
          out_data_nxt.frame_slot    = mfu_pkg::SLOT_OUT_W'(slot);
          out_data_nxt.evicted_valid = ev_valid;
          out_data_nxt.evicted_page  = mfu_pkg::IN_PAGE_W'(ev_page);
          out_data_nxt.fault_total   = fault_new;
          out_data_nxt.string_done   = last_r;
          // End of the string: the table and counters start over.
          if (last_r) begin
            valid_nxt = '0;
            stamp_nxt = '0;
            fault_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fiu_r       <= mfu_pkg::FIU_RESET;
      valid_r     <= '0;
      stamp_r     <= '0;
      fault_r     <= '0;
      rd_done_r   <= 1'b0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fiu_r       <= fiu_nxt;
      valid_r     <= valid_nxt;
      stamp_r     <= stamp_nxt;
      fault_r     <= fault_nxt;
      rd_done_r   <= rd_done_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    page_r     <= page_nxt;
    last_r     <= last_nxt;
    rd_idx_r   <= rd_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // A new result appears only from the write-back state.
  a_out_from_upd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_UPD))
    else $error("result raised outside write-back");

  // The last frame compared ends the scan.
  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    scan_end |=> (state_r == ST_UPD))
    else $error("scan did not hand over to write-back");

  // A hit never reports an eviction.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.hit && out_data_r.evicted_valid))
    else $error("hit reported with eviction");

  // A miss always leaves a nonzero fault total.
  a_miss_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.hit) |-> (out_data_r.fault_total != 32'd0))
    else $error("miss with zero fault total");

  // An accepted beat starts a scan.
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> ((state_r == ST_SCAN) && !rd_done_r && (rd_idx_r == '0)))
    else $error("accepted beat did not start a scan");
`endif

endmodule
